FILE: src/link_reconnect_supervisor_macros.svh
// Assertion macros for the link reconnect supervisor.
// Both forms sample on i_clk and are switched off while i_rst_n is low.
`ifndef LINK_RECONNECT_SUPERVISOR_MACROS_SVH
`define LINK_RECONNECT_SUPERVISOR_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define LRS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("supervisor check failed");

// The consequent must hold in the cycle after the antecedent.
`define LRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("supervisor check failed");

`else

`define LRS_ASSERT_SAME(label, ante, cons)
`define LRS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/lrs_pkg.sv
package lrs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE         = 3'd0,
        ST_CONNECTING   = 3'd1,
        ST_RECONNECTING = 3'd2,
        ST_PROVISIONING = 3'd3,
        ST_CONNECTED    = 3'd4
    } t_net_state;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_JOIN = 2'd1,
        ACT_DROP = 2'd2,
        ACT_AP   = 2'd3
    } t_radio_action;

    typedef enum logic [2:0] {
        CFG_CONNECT_TIMEOUT = 3'd0,
        CFG_FALLBACK_AFTER  = 3'd1,
        CFG_AP_RETRY        = 3'd2,
        CFG_BACKOFF_BASE    = 3'd3,
        CFG_BACKOFF_CAP     = 3'd4,
        CFG_BACKOFF_SHIFT   = 3'd5
    } t_cfg_reg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [7:0]  RETRY_MAX   = 8'hFF;

    localparam logic [31:0] RST_CONNECT_TIMEOUT = 32'd15000;
    localparam logic [31:0] RST_FALLBACK_AFTER  = 32'd300000;
    localparam logic [31:0] RST_AP_RETRY        = 32'd60000;
    localparam logic [31:0] RST_BACKOFF_BASE    = 32'd1000;
    localparam logic [31:0] RST_BACKOFF_CAP     = 32'd30000;
    localparam logic [4:0]  RST_BACKOFF_SHIFT   = 5'd5;

    typedef struct packed {
        logic [31:0] connect_timeout_ms;
        logic [31:0] fallback_after_ms;
        logic [31:0] ap_retry_ms;
        logic [31:0] backoff_base_ms;
        logic [31:0] backoff_cap_ms;
        logic [4:0]  backoff_max_shift;
    } t_cfg;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now_ms;
        logic        link_up;
        logic        credentials_valid;
        logic        ap_has_station;
        logic        connect_request;
        logic        provision_request;
        logic        forget_request;
    } t_item;

    typedef struct packed {
        t_net_state  state;
        logic [7:0]  retries;
        logic        pending_connect;
        logic        pending_provision;
        logic        pending_forget;
    } t_ctl;

    typedef struct packed {
        t_net_state    net_state;
        logic          state_changed;
        t_radio_action radio_action;
        logic          save_credentials;
        logic          clear_credentials;
        logic [7:0]    retry_count;
    } t_result;

endpackage

FILE: src/lrs_step.sv
module lrs_step #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  lrs_pkg::t_item         i_item,
    input  lrs_pkg::t_ctl          i_ctl,
    input  logic [TIME_WIDTH-1:0]  i_entered,
    input  logic [TIME_WIDTH-1:0]  i_offline,
    input  lrs_pkg::t_cfg          i_cfg,
    output lrs_pkg::t_ctl          o_ctl,
    output logic [TIME_WIDTH-1:0]  o_entered,
    output logic [TIME_WIDTH-1:0]  o_offline,
    output lrs_pkg::t_result       o_res
);

    localparam int unsigned NW = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
    localparam int unsigned CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    logic [TIME_WIDTH-1:0] w_now;
    logic [TIME_WIDTH-1:0] w_since_entered;
    logic [TIME_WIDTH-1:0] w_since_offline;
    logic                  w_pc;
    logic                  w_pp;
    logic                  w_pf;
    logic                  w_begin;
    logic                  w_serve_connect;
    logic [4:0]            w_shift;
    logic [63:0]           w_shifted;
    logic [31:0]           w_backoff;
    logic                  w_timeout_hit;
    logic                  w_fallback_hit;
    logic                  w_backoff_hit;
    logic                  w_ap_retry_hit;
    lrs_pkg::t_net_state   w_tgt;
    logic [7:0]            w_ret;
    logic [TIME_WIDTH-1:0] w_off;
    lrs_pkg::t_radio_action w_act;

    // Timestamps are zero extended or cut to the time width; differences wrap.
    assign w_now           = TIME_WIDTH'(i_item.now_ms[NW-1:0]);
    assign w_since_entered = w_now - i_entered;
    assign w_since_offline = w_now - i_offline;

    assign w_begin = i_item.cmd;
    assign w_pc    = i_ctl.pending_connect   | i_item.connect_request;
    assign w_pp    = i_ctl.pending_provision | i_item.provision_request;
    assign w_pf    = i_ctl.pending_forget    | i_item.forget_request;
    assign w_serve_connect = !w_begin && !w_pf && !w_pp && w_pc;

    // Backoff: base shifted by the saturated retry count, limited to the cap.
    assign w_shift   = (i_ctl.retries > {3'd0, i_cfg.backoff_max_shift})
                       ? i_cfg.backoff_max_shift : i_ctl.retries[4:0];
    assign w_shifted = {32'd0, i_cfg.backoff_base_ms} << w_shift;
    assign w_backoff = (w_shifted > {32'd0, i_cfg.backoff_cap_ms})
                       ? i_cfg.backoff_cap_ms : w_shifted[31:0];

    assign w_timeout_hit  = CW'(w_since_entered) >= CW'(i_cfg.connect_timeout_ms);
    assign w_fallback_hit = CW'(w_since_offline) >  CW'(i_cfg.fallback_after_ms);
    assign w_backoff_hit  = CW'(w_since_entered) >= CW'(w_backoff);
    assign w_ap_retry_hit = CW'(w_since_entered) >= CW'(i_cfg.ap_retry_ms);

    // Next state and the timing registers.
    always_comb begin
        w_tgt = i_ctl.state;
        w_ret = i_ctl.retries;
        w_off = i_offline;
        if (w_begin) begin
            w_off = w_now;
            w_tgt = (w_pp || !i_item.credentials_valid) ? lrs_pkg::ST_PROVISIONING
                                                        : lrs_pkg::ST_CONNECTING;
        end else if (w_pf || w_pp) begin
            w_tgt = lrs_pkg::ST_PROVISIONING;
        end else if (w_pc) begin
            w_ret = 8'd0;
            w_off = w_now;
            w_tgt = lrs_pkg::ST_CONNECTING;
        end else begin
            case (i_ctl.state)
                lrs_pkg::ST_CONNECTING: begin
                    if (i_item.link_up) begin
                        w_ret = 8'd0;
                        w_tgt = lrs_pkg::ST_CONNECTED;
                    end else if (w_timeout_hit) begin
                        if (i_ctl.retries != lrs_pkg::RETRY_MAX) begin
                            w_ret = i_ctl.retries + 8'd1;
                        end
                        w_tgt = lrs_pkg::ST_RECONNECTING;
                    end
                end
                lrs_pkg::ST_RECONNECTING: begin
                    if (w_fallback_hit) begin
                        w_tgt = lrs_pkg::ST_PROVISIONING;
                    end else if (w_backoff_hit) begin
                        w_tgt = i_item.credentials_valid ? lrs_pkg::ST_CONNECTING
                                                         : lrs_pkg::ST_PROVISIONING;
                    end
                end
                lrs_pkg::ST_PROVISIONING: begin
                    if (i_item.credentials_valid && !i_item.ap_has_station &&
                        w_ap_retry_hit) begin
                        w_ret = 8'd0;
                        w_off = w_now;
                        w_tgt = lrs_pkg::ST_CONNECTING;
                    end
                end
                lrs_pkg::ST_CONNECTED: begin
                    if (!i_item.link_up) begin
                        w_off = w_now;
                        w_tgt = lrs_pkg::ST_RECONNECTING;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Outputs. Every move into a state carries that state's radio action, so
    // the action follows from whether a move was made and where to.
    always_comb begin
        w_act = lrs_pkg::ACT_NONE;
        if (w_begin || w_pf || w_pp || w_pc ||
            (w_tgt != i_ctl.state) || (w_ret != i_ctl.retries)) begin
            case (w_tgt)
                lrs_pkg::ST_CONNECTING:   w_act = lrs_pkg::ACT_JOIN;
                lrs_pkg::ST_RECONNECTING: w_act = lrs_pkg::ACT_DROP;
                lrs_pkg::ST_PROVISIONING: w_act = lrs_pkg::ACT_AP;
                default:                  w_act = lrs_pkg::ACT_NONE;
            endcase
        end
    end

    assign o_ctl.state             = w_tgt;
    assign o_ctl.retries           = w_ret;
    assign o_ctl.pending_connect   = w_pc && !w_serve_connect;
    assign o_ctl.pending_provision = w_pp && !(w_begin || !w_pf);
    assign o_ctl.pending_forget    = w_pf && w_begin;
    assign o_entered = (w_tgt != i_ctl.state) ? w_now : i_entered;
    assign o_offline = w_off;

    assign o_res.net_state         = w_tgt;
    assign o_res.state_changed     = (w_tgt != i_ctl.state);
    assign o_res.radio_action      = w_act;
    assign o_res.save_credentials  = w_serve_connect;
    assign o_res.clear_credentials = !w_begin && w_pf;
    assign o_res.retry_count       = w_ret;

endmodule

FILE: src/link_reconnect_supervisor.sv
// Channel   Valid        Stall / ready   Payload
// input     i_in_valid   o_in_stall      i_cmd, i_now_ms, status and request bits
// output    o_out_valid  i_out_stall     o_net_state ... o_retry_count
// config    i_cfg_valid  o_cfg_ready     i_cfg_index, i_cfg_data
//
// One word is taken per cycle while the input is not stalled; its result passes
// through the input register, then the result register. Register writes are
// always ready. Reset (i_rst_n low at a clock edge) restores register defaults,
// idle state, zero timestamps, zero retries and no pending requests.
// An output stall holds the result register; the input stalls only when its
// staged word cannot move into a full, stalled result register.

`include "link_reconnect_supervisor_macros.svh"

module link_reconnect_supervisor #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_now_ms,
    input  logic        i_link_up,
    input  logic        i_credentials_valid,
    input  logic        i_ap_has_station,
    input  logic        i_connect_request,
    input  logic        i_provision_request,
    input  logic        i_forget_request,
    // Result words
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_net_state,
    output logic        o_state_changed,
    output logic [1:0]  o_radio_action,
    output logic        o_save_credentials,
    output logic        o_clear_credentials,
    output logic [7:0]  o_retry_count,
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [lrs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // Staged input word.
    logic                  r_in_valid;
    lrs_pkg::t_item        r_item;
    // Supervisor state.
    lrs_pkg::t_ctl         r_ctl;
    logic [TIME_WIDTH-1:0] r_entered;
    logic [TIME_WIDTH-1:0] r_offline;
    lrs_pkg::t_cfg         r_cfg;
    // Result register.
    logic                  r_out_valid;
    lrs_pkg::t_result      r_res;

    lrs_pkg::t_ctl         n_ctl;
    logic [TIME_WIDTH-1:0] n_entered;
    logic [TIME_WIDTH-1:0] n_offline;
    lrs_pkg::t_result      n_res;

    logic                  w_load;
    logic                  w_take;

    // The staged word is decided and its result loaded whenever the result
    // register is empty or is being emptied in this cycle.
    assign w_load     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_load;
    assign w_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    lrs_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .i_item    (r_item),
        .i_ctl     (r_ctl),
        .i_entered (r_entered),
        .i_offline (r_offline),
        .i_cfg     (r_cfg),
        .o_ctl     (n_ctl),
        .o_entered (n_entered),
        .o_offline (n_offline),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.cmd               <= i_cmd;
            r_item.now_ms            <= i_now_ms;
            r_item.link_up           <= i_link_up;
            r_item.credentials_valid <= i_credentials_valid;
            r_item.ap_has_station    <= i_ap_has_station;
            r_item.connect_request   <= i_connect_request;
            r_item.provision_request <= i_provision_request;
            r_item.forget_request    <= i_forget_request;
        end
    end

    // Supervisor state moves only when a word is decided.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.state             <= lrs_pkg::ST_IDLE;
            r_ctl.retries           <= 8'd0;
            r_ctl.pending_connect   <= 1'b0;
            r_ctl.pending_provision <= 1'b0;
            r_ctl.pending_forget    <= 1'b0;
            r_entered               <= '0;
            r_offline               <= '0;
        end else if (w_load) begin
            r_ctl     <= n_ctl;
            r_entered <= n_entered;
            r_offline <= n_offline;
        end
    end

    // Register file; writes outside the list are accepted and ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.connect_timeout_ms <= lrs_pkg::RST_CONNECT_TIMEOUT;
            r_cfg.fallback_after_ms  <= lrs_pkg::RST_FALLBACK_AFTER;
            r_cfg.ap_retry_ms        <= lrs_pkg::RST_AP_RETRY;
            r_cfg.backoff_base_ms    <= lrs_pkg::RST_BACKOFF_BASE;
            r_cfg.backoff_cap_ms     <= lrs_pkg::RST_BACKOFF_CAP;
            r_cfg.backoff_max_shift  <= lrs_pkg::RST_BACKOFF_SHIFT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lrs_pkg::CFG_CONNECT_TIMEOUT: r_cfg.connect_timeout_ms <= i_cfg_data;
                lrs_pkg::CFG_FALLBACK_AFTER:  r_cfg.fallback_after_ms  <= i_cfg_data;
                lrs_pkg::CFG_AP_RETRY:        r_cfg.ap_retry_ms        <= i_cfg_data;
                lrs_pkg::CFG_BACKOFF_BASE:    r_cfg.backoff_base_ms    <= i_cfg_data;
                lrs_pkg::CFG_BACKOFF_CAP:     r_cfg.backoff_cap_ms     <= i_cfg_data;
                lrs_pkg::CFG_BACKOFF_SHIFT:   r_cfg.backoff_max_shift  <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_net_state         = r_res.net_state;
    assign o_state_changed     = r_res.state_changed;
    assign o_radio_action      = r_res.radio_action;
    assign o_save_credentials  = r_res.save_credentials;
    assign o_clear_credentials = r_res.clear_credentials;
    assign o_retry_count       = r_res.retry_count;

    // A saturated retry count either stays saturated or is cleared.
    `LRS_ASSERT_NEXT(a_retry_saturates, r_ctl.retries == lrs_pkg::RETRY_MAX,
                     r_ctl.retries == lrs_pkg::RETRY_MAX || r_ctl.retries == 8'd0)
    // A change of state stamps the entry time with the word's timestamp.
    `LRS_ASSERT_NEXT(a_entry_stamped, w_load && n_ctl.state != r_ctl.state,
                     r_entered == $past(n_entered))
    // Being connected means no timeouts are outstanding.
    `LRS_ASSERT_SAME(a_connected_no_retry, r_ctl.state == lrs_pkg::ST_CONNECTED,
                     r_ctl.retries == 8'd0)

endmodule

FILE: bench/link_reconnect_supervisor_tb.sv
// Testbench for the link reconnect supervisor.
//
// Words are offered on the input channel in bursts with random gaps, while the
// result channel stalls on a pattern of its own. Every accepted input word is
// run through a behavioural copy of the supervisor kept in this module. That
// copy holds its own state and its own view of the registers. Its prediction,
// or a typed-in expectation where a directed row gives one, is queued, and each
// accepted result word is compared field by field with the oldest queue entry.
//
// The run opens with a short table of directed words against the register
// defaults. It then goes through a retry saturation phase and a series of
// register settings, the extremes among them. Between phases the input is
// drained before the registers are rewritten, so the block is idle whenever it
// sees a register write.

module link_reconnect_supervisor_tb;

    import lrs_pkg::*;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_BEGIN = 1'b1;

    // Cycles with no handshake on any channel before the run is abandoned.
    // The longest deliberate hold-off on the result side is shorter than this limit.
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned PHASE_WORDS = 170;
    localparam int unsigned SAT_WORDS   = 530;
    localparam int          NUM_PHASES  = 7;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_cmd;
    logic [31:0] i_now_ms;
    logic        i_link_up;
    logic        i_credentials_valid;
    logic        i_ap_has_station;
    logic        i_connect_request;
    logic        i_provision_request;
    logic        i_forget_request;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_net_state;
    logic        o_state_changed;
    logic [1:0]  o_radio_action;
    logic        o_save_credentials;
    logic        o_clear_credentials;
    logic [7:0]  o_retry_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    link_reconnect_supervisor u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_cmd               (i_cmd),
        .i_now_ms            (i_now_ms),
        .i_link_up           (i_link_up),
        .i_credentials_valid (i_credentials_valid),
        .i_ap_has_station    (i_ap_has_station),
        .i_connect_request   (i_connect_request),
        .i_provision_request (i_provision_request),
        .i_forget_request    (i_forget_request),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_net_state         (o_net_state),
        .o_state_changed     (o_state_changed),
        .o_radio_action      (o_radio_action),
        .o_save_credentials  (o_save_credentials),
        .o_clear_credentials (o_clear_credentials),
        .o_retry_count       (o_retry_count),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Behavioural copy of the supervisor. It is advanced once per accepted
    // input word and updated on every accepted register write.
    // ------------------------------------------------------------------
    t_cfg          sup_cfg;
    t_net_state    sup_state;
    logic [31:0]   sup_entered;
    logic [31:0]   sup_offline;
    logic [31:0]   sup_now;
    logic [7:0]    sup_retries;
    logic          sup_pend_connect;
    logic          sup_pend_provision;
    logic          sup_pend_forget;
    t_radio_action sup_action;

    // Time differences wrap modulo 2^32, as the timestamps do.
    function automatic logic [31:0] elapsed(logic [31:0] since_ms);
        return sup_now - since_ms;
    endfunction

    // The radio action is emitted even when the state does not change, but
    // the entry time is only refreshed on a real change of state.
    function automatic void enter(t_net_state s, t_radio_action a);
        sup_action = a;
        if (s != sup_state) begin
            sup_state   = s;
            sup_entered = sup_now;
        end
    endfunction

    // The base is shifted at 64 bits so that nothing is lost before the cap.
    function automatic logic [31:0] backoff_delay();
        logic [4:0]  sh;
        logic [63:0] d;
        sh = (sup_retries > sup_cfg.backoff_max_shift) ? sup_cfg.backoff_max_shift
                                                       : sup_retries[4:0];
        d  = {32'd0, sup_cfg.backoff_base_ms} << sh;
        return (d > {32'd0, sup_cfg.backoff_cap_ms}) ? sup_cfg.backoff_cap_ms : d[31:0];
    endfunction

    function automatic t_result step_supervisor(t_item w);
        t_net_state prior;
        logic       save;
        logic       clear;
        t_result    r;
        prior      = sup_state;
        save       = 1'b0;
        clear      = 1'b0;
        sup_now    = w.now_ms;
        sup_action = ACT_NONE;
        // Requests are latched first; a tick then serves at most one of them.
        if (w.connect_request)   sup_pend_connect   = 1'b1;
        if (w.provision_request) sup_pend_provision = 1'b1;
        if (w.forget_request)    sup_pend_forget    = 1'b1;

        if (w.cmd == CMD_BEGIN) begin
            // Start-up decision: only the provision latch is served here.
            sup_offline = sup_now;
            if (sup_pend_provision) begin
                sup_pend_provision = 1'b0;
                enter(ST_PROVISIONING, ACT_AP);
            end else if (w.credentials_valid) begin
                enter(ST_CONNECTING, ACT_JOIN);
            end else begin
                enter(ST_PROVISIONING, ACT_AP);
            end
        end else if (sup_pend_forget) begin
            sup_pend_forget = 1'b0;
            clear = 1'b1;
            enter(ST_PROVISIONING, ACT_AP);
        end else if (sup_pend_provision) begin
            sup_pend_provision = 1'b0;
            enter(ST_PROVISIONING, ACT_AP);
        end else if (sup_pend_connect) begin
            sup_pend_connect = 1'b0;
            save        = 1'b1;
            sup_retries = '0;
            sup_offline = sup_now;
            enter(ST_CONNECTING, ACT_JOIN);
        end else begin
            case (sup_state)
                ST_CONNECTING: begin
                    if (w.link_up) begin
                        sup_retries = '0;
                        enter(ST_CONNECTED, ACT_NONE);
                    end else if (elapsed(sup_entered) >= sup_cfg.connect_timeout_ms) begin
                        if (sup_retries != RETRY_MAX) sup_retries = sup_retries + 8'd1;
                        enter(ST_RECONNECTING, ACT_DROP);
                    end
                end
                ST_RECONNECTING: begin
                    // Fallback to the access point takes precedence over backoff.
                    if (elapsed(sup_offline) > sup_cfg.fallback_after_ms) begin
                        enter(ST_PROVISIONING, ACT_AP);
                    end else if (elapsed(sup_entered) >= backoff_delay()) begin
                        if (w.credentials_valid) enter(ST_CONNECTING, ACT_JOIN);
                        else enter(ST_PROVISIONING, ACT_AP);
                    end
                end
                ST_PROVISIONING: begin
                    if (w.credentials_valid && !w.ap_has_station &&
                        elapsed(sup_entered) >= sup_cfg.ap_retry_ms) begin
                        sup_retries = '0;
                        sup_offline = sup_now;
                        enter(ST_CONNECTING, ACT_JOIN);
                    end
                end
                ST_CONNECTED: begin
                    if (!w.link_up) begin
                        sup_offline = sup_now;
                        enter(ST_RECONNECTING, ACT_DROP);
                    end
                end
                default: begin
                end
            endcase
        end

        r.net_state         = sup_state;
        r.state_changed     = (sup_state != prior);
        r.radio_action      = sup_action;
        r.save_credentials  = save;
        r.clear_credentials = clear;
        r.retry_count       = sup_retries;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Expected results and the result-side check.
    // ------------------------------------------------------------------
    t_result     expected_results[$];
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen = results_seen + 1;
            if (expected_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("result word %0d arrived with nothing expected", results_seen);
            end else begin
                e = expected_results.pop_front();
                if (o_net_state !== e.net_state || o_state_changed !== e.state_changed ||
                    o_radio_action !== e.radio_action ||
                    o_save_credentials !== e.save_credentials ||
                    o_clear_credentials !== e.clear_credentials ||
                    o_retry_count !== e.retry_count) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result word %0d: exp st %0d chg %0b act %0d sv %0b clr %0b rt %0d",
                                 results_seen, e.net_state, e.state_changed, e.radio_action,
                                 e.save_credentials, e.clear_credentials, e.retry_count,
                                 " / got st %0d chg %0b act %0d sv %0b clr %0b rt %0d",
                                 o_net_state, o_state_changed, o_radio_action,
                                 o_save_credentials, o_clear_credentials, o_retry_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any handshake on any channel restarts the count.
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Result-side stall pattern. Segments of random length pick a stall
    // density, from none at all to mostly stalled. A hold-off request from
    // the stimulus process stalls the output solidly, which backs the block
    // up until it stalls its input.
    // ------------------------------------------------------------------
    bit holdoff_req = 1'b0;

    initial begin
        int unsigned hold_left;
        int unsigned seg_left;
        int unsigned density;
        hold_left = 0;
        seg_left  = 0;
        density   = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 80);
                    density  = $urandom_range(0, 3);
                end
                seg_left = seg_left - 1;
                case (density)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 1) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side: one word per call, held until the block takes it.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gapless    = 0;

    task automatic send_word(t_item w, bit typed, t_result r);
        t_result p;
        i_in_valid          <= 1'b1;
        i_cmd               <= w.cmd;
        i_now_ms            <= w.now_ms;
        i_link_up           <= w.link_up;
        i_credentials_valid <= w.credentials_valid;
        i_ap_has_station    <= w.ap_has_station;
        i_connect_request   <= w.connect_request;
        i_provision_request <= w.provision_request;
        i_forget_request    <= w.forget_request;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // The word was taken at this edge; the copy always advances, but a
        // typed-in expectation replaces its prediction where one is given.
        p = step_supervisor(w);
        expected_results.push_back(typed ? r : p);
    endtask

    // Bursts of random length separated by random gaps. Valid is only
    // lowered when a gap actually follows.
    task automatic pace();
        if (gapless != 0) begin
            gapless = gapless - 1;
        end else if (burst_left != 0) begin
            burst_left = burst_left - 1;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Every result has been seen when this is called, so the block is idle.
    task automatic write_reg(t_cfg_reg idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_CONNECT_TIMEOUT: sup_cfg.connect_timeout_ms = val;
            CFG_FALLBACK_AFTER:  sup_cfg.fallback_after_ms  = val;
            CFG_AP_RETRY:        sup_cfg.ap_retry_ms        = val;
            CFG_BACKOFF_BASE:    sup_cfg.backoff_base_ms    = val;
            CFG_BACKOFF_CAP:     sup_cfg.backoff_cap_ms     = val;
            CFG_BACKOFF_SHIFT:   sup_cfg.backoff_max_shift  = val[4:0];
            default: begin
            end
        endcase
    endtask

    task automatic apply_settings(t_cfg s);
        write_reg(CFG_CONNECT_TIMEOUT, s.connect_timeout_ms);
        write_reg(CFG_FALLBACK_AFTER, s.fallback_after_ms);
        write_reg(CFG_AP_RETRY, s.ap_retry_ms);
        write_reg(CFG_BACKOFF_BASE, s.backoff_base_ms);
        write_reg(CFG_BACKOFF_CAP, s.backoff_cap_ms);
        // Only the low five bits of the shift register count; the rest is junk.
        write_reg(CFG_BACKOFF_SHIFT, ($urandom() & ~32'd31) | {27'd0, s.backoff_max_shift});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_cfg scaled_settings(int unsigned scale);
        t_cfg s;
        s.connect_timeout_ms = $urandom_range(0, 4 * scale);
        s.fallback_after_ms  = $urandom_range(0, 40 * scale);
        s.ap_retry_ms        = $urandom_range(0, 8 * scale);
        s.backoff_base_ms    = $urandom_range(0, scale);
        s.backoff_cap_ms     = $urandom_range(0, 8 * scale);
        s.backoff_max_shift  = $urandom_range(0, 31);
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Random words. Most follow a running clock whose steps match the
    // register scale, with a sticky link status, so the timing rules are
    // reached. Now and then the clock jumps anywhere, and a few words are
    // pure noise with every field random.
    // ------------------------------------------------------------------
    logic [31:0] clock_ms   = '0;
    logic        link_level = 1'b0;

    function automatic t_item next_stimulus(int unsigned step_max);
        t_item w;
        if ($urandom_range(0, 11) == 0) begin
            w.cmd               = $urandom_range(0, 1);
            w.now_ms            = $urandom();
            w.link_up           = $urandom_range(0, 1);
            w.credentials_valid = $urandom_range(0, 1);
            w.ap_has_station    = $urandom_range(0, 1);
            w.connect_request   = $urandom_range(0, 1);
            w.provision_request = $urandom_range(0, 1);
            w.forget_request    = $urandom_range(0, 1);
            return w;
        end
        if ($urandom_range(0, 63) == 0) clock_ms = $urandom();
        else clock_ms = clock_ms + $urandom_range(0, step_max);
        if ($urandom_range(0, 9) == 0) link_level = ~link_level;
        w.cmd               = ($urandom_range(0, 39) == 0) ? CMD_BEGIN : CMD_TICK;
        w.now_ms            = clock_ms;
        w.link_up           = link_level;
        w.credentials_valid = ($urandom_range(0, 4) != 0);
        w.ap_has_station    = ($urandom_range(0, 4) == 0);
        w.connect_request   = ($urandom_range(0, 29) == 0);
        w.provision_request = ($urandom_range(0, 29) == 0);
        w.forget_request    = ($urandom_range(0, 29) == 0);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Directed table.
    // ------------------------------------------------------------------
    typedef struct {
        t_item   w;
        bit      typed;
        t_result r;
    } dir_row_t;

    dir_row_t directed_rows[$];

    function automatic t_item word_of(logic cmd, logic [31:0] now, logic link, logic cred,
                                      logic sta, logic creq, logic preq, logic freq);
        t_item w;
        w.cmd               = cmd;
        w.now_ms            = now;
        w.link_up           = link;
        w.credentials_valid = cred;
        w.ap_has_station    = sta;
        w.connect_request   = creq;
        w.provision_request = preq;
        w.forget_request    = freq;
        return w;
    endfunction

    function automatic t_result outcome(t_net_state s, logic chg, t_radio_action a,
                                        logic sv, logic clr, logic [7:0] rt);
        t_result r;
        r.net_state         = s;
        r.state_changed     = chg;
        r.radio_action      = a;
        r.save_credentials  = sv;
        r.clear_credentials = clr;
        r.retry_count       = rt;
        return r;
    endfunction

    function automatic void add_row(t_item w, bit typed, t_result r);
        dir_row_t row;
        row.w     = w;
        row.typed = typed;
        row.r     = r;
        directed_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin
        t_cfg        phase_cfg[NUM_PHASES];
        int unsigned phase_step[NUM_PHASES];
        t_cfg        sat_cfg;
        t_item       w;

        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_cmd               <= CMD_TICK;
        i_now_ms            <= '0;
        i_link_up           <= 1'b0;
        i_credentials_valid <= 1'b0;
        i_ap_has_station    <= 1'b0;
        i_connect_request   <= 1'b0;
        i_provision_request <= 1'b0;
        i_forget_request    <= 1'b0;
        i_cfg_valid         <= 1'b0;
        i_cfg_index         <= CFG_CONNECT_TIMEOUT;
        i_cfg_data          <= '0;

        sup_cfg.connect_timeout_ms = RST_CONNECT_TIMEOUT;
        sup_cfg.fallback_after_ms  = RST_FALLBACK_AFTER;
        sup_cfg.ap_retry_ms        = RST_AP_RETRY;
        sup_cfg.backoff_base_ms    = RST_BACKOFF_BASE;
        sup_cfg.backoff_cap_ms     = RST_BACKOFF_CAP;
        sup_cfg.backoff_max_shift  = RST_BACKOFF_SHIFT;
        sup_state          = ST_IDLE;
        sup_entered        = '0;
        sup_offline        = '0;
        sup_retries        = '0;
        sup_pend_connect   = 1'b0;
        sup_pend_provision = 1'b0;
        sup_pend_forget    = 1'b0;

        // Directed words, all against the register defaults.
        // A tick while idle does nothing.
        add_row(word_of(CMD_TICK, 32'd0, 0, 0, 0, 0, 0, 0), 1,
                outcome(ST_IDLE, 0, ACT_NONE, 0, 0, 0));
        // Begin without credentials goes straight to provisioning.
        add_row(word_of(CMD_BEGIN, 32'd100, 0, 0, 0, 0, 0, 0), 1,
                outcome(ST_PROVISIONING, 1, ACT_AP, 0, 0, 0));
        // A client on the access point blocks the retry; then the retry
        // interval is met exactly.
        add_row(word_of(CMD_TICK, 32'd200, 0, 1, 1, 0, 0, 0), 0, '0);
        add_row(word_of(CMD_TICK, 32'd60100, 0, 1, 0, 0, 0, 0), 0, '0);
        // Connect timeout just short of, then exactly at, the limit.
        add_row(word_of(CMD_TICK, 32'd60200, 0, 1, 0, 0, 0, 0), 0, '0);
        add_row(word_of(CMD_TICK, 32'd75100, 0, 1, 0, 0, 0, 0), 0, '0);
        // Backoff for one retry is twice the base.
        add_row(word_of(CMD_TICK, 32'd76000, 0, 1, 0, 0, 0, 0), 0, '0);
        add_row(word_of(CMD_TICK, 32'd77100, 0, 1, 0, 0, 0, 0), 0, '0);
        add_row(word_of(CMD_TICK, 32'd77200, 1, 1, 0, 0, 0, 0), 0, '0);
        add_row(word_of(CMD_TICK, 32'd80000, 0, 1, 0, 0, 0, 0), 0, '0);
        add_row(word_of(CMD_TICK, 32'd80500, 0, 1, 0, 0, 0, 0), 0, '0);
        // Offline for longer than the fallback time: access point wins.
        add_row(word_of(CMD_TICK, 32'd380001, 0, 1, 0, 0, 0, 0), 0, '0);
        // A connect request saves the credentials and clears the retries.
        add_row(word_of(CMD_TICK, 32'd380100, 0, 1, 0, 1, 0, 0), 1,
                outcome(ST_CONNECTING, 1, ACT_JOIN, 1, 0, 0));
        // All three requests at once are served forget, provision, connect.
        add_row(word_of(CMD_TICK, 32'd380200, 0, 1, 0, 1, 1, 1), 1,
                outcome(ST_PROVISIONING, 1, ACT_AP, 0, 1, 0));
        // Provisioning again: the action is repeated but nothing changes.
        add_row(word_of(CMD_TICK, 32'd380300, 0, 1, 0, 0, 0, 0), 1,
                outcome(ST_PROVISIONING, 0, ACT_AP, 0, 0, 0));
        add_row(word_of(CMD_TICK, 32'd380400, 0, 1, 0, 0, 0, 0), 1,
                outcome(ST_CONNECTING, 1, ACT_JOIN, 1, 0, 0));
        // Begin serves only the provision latch; forget and connect wait.
        add_row(word_of(CMD_BEGIN, 32'd380500, 0, 1, 0, 1, 1, 1), 1,
                outcome(ST_PROVISIONING, 1, ACT_AP, 0, 0, 0));
        add_row(word_of(CMD_TICK, 32'd380600, 0, 1, 0, 0, 0, 0), 1,
                outcome(ST_PROVISIONING, 0, ACT_AP, 0, 1, 0));
        add_row(word_of(CMD_TICK, 32'hFFFF_F000, 0, 1, 0, 0, 0, 0), 1,
                outcome(ST_CONNECTING, 1, ACT_JOIN, 1, 0, 0));
        // Begin while connecting keeps the entry time.
        add_row(word_of(CMD_BEGIN, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0), 1,
                outcome(ST_CONNECTING, 0, ACT_JOIN, 0, 0, 0));
        // The timeout is measured across the wrap of the timestamp.
        add_row(word_of(CMD_TICK, 32'h0000_2A97, 0, 1, 0, 0, 0, 0), 0, '0);
        add_row(word_of(CMD_TICK, 32'h0000_2A98, 0, 1, 0, 0, 0, 0), 0, '0);
        // Every status bit high on a begin without credentials.
        add_row(word_of(CMD_BEGIN, 32'hFFFF_FFFF, 1, 0, 1, 1, 0, 1), 0, '0);
        add_row(word_of(CMD_TICK, 32'd0, 1, 1, 1, 0, 0, 0), 0, '0);
        add_row(word_of(CMD_TICK, 32'd1, 1, 1, 1, 0, 0, 0), 0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_word(directed_rows[k].w, directed_rows[k].typed, directed_rows[k].r);
            pace();
        end
        drain();

        // Retry saturation: no timeout and no backoff, so every pair of ticks
        // counts one more retry, well past the shift limit and up to 255.
        sat_cfg.connect_timeout_ms = '0;
        sat_cfg.fallback_after_ms  = 32'hFFFF_FFFF;
        sat_cfg.ap_retry_ms        = '0;
        sat_cfg.backoff_base_ms    = '0;
        sat_cfg.backoff_cap_ms     = '0;
        sat_cfg.backoff_max_shift  = 5'd31;
        apply_settings(sat_cfg);
        for (int unsigned n = 0; n < SAT_WORDS; n++) begin
            w = next_stimulus(50);
            w.cmd               = (n == 0) ? CMD_BEGIN : CMD_TICK;
            w.link_up           = 1'b0;
            w.credentials_valid = 1'b1;
            w.ap_has_station    = 1'b0;
            w.connect_request   = 1'b0;
            w.provision_request = 1'b0;
            w.forget_request    = 1'b0;
            send_word(w, 0, '0);
            pace();
        end
        drain();

        phase_cfg[0].connect_timeout_ms = RST_CONNECT_TIMEOUT;
        phase_cfg[0].fallback_after_ms  = RST_FALLBACK_AFTER;
        phase_cfg[0].ap_retry_ms        = RST_AP_RETRY;
        phase_cfg[0].backoff_base_ms    = RST_BACKOFF_BASE;
        phase_cfg[0].backoff_cap_ms     = RST_BACKOFF_CAP;
        phase_cfg[0].backoff_max_shift  = RST_BACKOFF_SHIFT;
        phase_step[0] = 2000;
        phase_cfg[1]  = scaled_settings(8);
        phase_step[1] = 8;
        phase_cfg[2]  = scaled_settings(500);
        phase_step[2] = 500;
        phase_cfg[3]  = '0;
        phase_step[3] = 3;
        phase_cfg[4]  = scaled_settings(20000);
        phase_step[4] = 20000;
        // Largest values everywhere: the 64-bit backoff shift and the cap.
        phase_cfg[5]  = '1;
        phase_step[5] = 32'hFFFF_FFFF;
        phase_cfg[6]  = scaled_settings(100000);
        phase_step[6] = 100000;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            apply_settings(phase_cfg[ph]);
            if (ph == 2) begin
                // Long hold-off on the result side while words keep coming
                // back to back, so the block fills and stalls its input.
                holdoff_req = 1'b1;
                gapless     = 40;
            end
            for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
                send_word(next_stimulus(phase_step[ph]), 0, '0);
                pace();
            end
            // The sender pauses here until every result is back.
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
